// ===== hdl/sspq_pkg.sv =====
// Shared constants and types for the stable sorted priority queue.
`timescale 1ns / 1ps

package sspq_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== hdl/sspq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares, shifts toward either neighbour.
`timescale 1ns / 1ps

module sspq_cell (
    input  logic                                i_clk,
    input  sspq_pkg::t_cell_ctl                 i_ctl,
    input  logic                                i_occ,
    input  logic [sspq_pkg::KEY_BITS-1:0]       i_new_key,
    input  logic [sspq_pkg::PAYLOAD_BITS-1:0]   i_new_payload,
    input  logic                                i_prev_gt,
    input  logic [sspq_pkg::KEY_BITS-1:0]       i_prev_key,
    input  logic [sspq_pkg::PAYLOAD_BITS-1:0]   i_prev_payload,
    input  logic [sspq_pkg::KEY_BITS-1:0]       i_next_key,
    input  logic [sspq_pkg::PAYLOAD_BITS-1:0]   i_next_payload,
    output logic                                o_gt,
    output logic [sspq_pkg::KEY_BITS-1:0]       o_key,
    output logic [sspq_pkg::PAYLOAD_BITS-1:0]   o_payload
);

    logic [sspq_pkg::KEY_BITS-1:0]     r_key;
    logic [sspq_pkg::PAYLOAD_BITS-1:0] r_payload;
    logic [sspq_pkg::KEY_BITS-1:0]     n_key;
    logic [sspq_pkg::PAYLOAD_BITS-1:0] n_payload;

    assign o_gt      = i_occ && (r_key > i_new_key);
    assign o_key     = r_key;
    assign o_payload = r_payload;

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_key     = i_prev_key;
                n_payload = i_prev_payload;
            end else if (o_gt || !i_occ) begin
                n_key     = i_new_key;
                n_payload = i_new_payload;
            end
        end else if (i_ctl.rem) begin
            n_key     = i_next_key;
            n_payload = i_next_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

endmodule

// ===== hdl/stable_sorted_priority_queue.sv =====
// Top level of the stable sorted priority queue: cell chain, count and result register.
//
// Input channel: i_valid, o_stall, i_opcode, i_entry_key, i_entry_payload.
// A transfer happens on a rising edge with i_valid high and o_stall low.
// Insert places the entry behind every held entry of equal or smaller key;
// remove returns the entry with the smallest key (oldest among equals).
// Output channel: o_valid, i_stall and the result fields; one result per item.
// The result is registered and appears in the cycle after the input transfer.
// Throughput: one item per cycle while o_stall is low; every cell compares against
// the new key and shifts toward its neighbour in the same cycle, so the chain
// completes an insert or remove as one update of all cells.
// An insert into a full queue returns status full, a remove from an empty
// queue returns status empty; neither changes the contents.
// While the receiver stalls a held result, o_stall is raised and the result
// holds; a free result register lets a new item in even under stall.
// Reset (synchronous, active low) empties the queue and drops any pending result.
`timescale 1ns / 1ps

module stable_sorted_priority_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic [sspq_pkg::KEY_BITS-1:0]       i_entry_key,
    input  logic [sspq_pkg::PAYLOAD_BITS-1:0]   i_entry_payload,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic [sspq_pkg::KEY_BITS-1:0]       o_out_key,
    output logic [sspq_pkg::PAYLOAD_BITS-1:0]   o_out_payload,
    output logic [sspq_pkg::CNT_BITS-1:0]       o_entry_count,
    output logic                                o_is_empty,
    output logic                                o_is_full
);

    localparam int D = sspq_pkg::DEPTH;

    logic [sspq_pkg::CNT_BITS-1:0]     r_count;
    logic [sspq_pkg::CNT_BITS-1:0]     n_count;
    logic                              r_valid;
    logic [1:0]                        r_status;
    logic [1:0]                        n_status;
    logic [sspq_pkg::KEY_BITS-1:0]     r_key;
    logic [sspq_pkg::KEY_BITS-1:0]     n_key;
    logic [sspq_pkg::PAYLOAD_BITS-1:0] r_payload;
    logic [sspq_pkg::PAYLOAD_BITS-1:0] n_payload;
    logic [sspq_pkg::CNT_BITS-1:0]     r_out_count;

    logic                              accept;
    logic                              full;
    logic                              empty;
    sspq_pkg::t_cell_ctl               ctl;

    logic [D-1:0]                      occ;
    logic [D-1:0]                      gt;
    logic [sspq_pkg::KEY_BITS-1:0]     cell_key [D];
    logic [sspq_pkg::PAYLOAD_BITS-1:0] cell_payload [D];

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign full    = (r_count == sspq_pkg::CNT_BITS'(D));
    assign empty   = (r_count == '0);
    assign ctl.ins = accept && (i_opcode == sspq_pkg::OP_INSERT) && !full;
    assign ctl.rem = accept && (i_opcode == sspq_pkg::OP_REMOVE) && !empty;

    for (genvar g = 0; g < D; g++) begin : g_cell
        assign occ[g] = (r_count > sspq_pkg::CNT_BITS'(g));
        if (g == 0) begin : g_first
            sspq_cell u_cell (
                .i_clk          (i_clk),
                .i_ctl          (ctl),
                .i_occ          (occ[g]),
                .i_new_key      (i_entry_key),
                .i_new_payload  (i_entry_payload),
                .i_prev_gt      (1'b0),
                .i_prev_key     (i_entry_key),
                .i_prev_payload (i_entry_payload),
                .i_next_key     (cell_key[g+1]),
                .i_next_payload (cell_payload[g+1]),
                .o_gt           (gt[g]),
                .o_key          (cell_key[g]),
                .o_payload      (cell_payload[g])
            );
        end else if (g == D - 1) begin : g_last
            sspq_cell u_cell (
                .i_clk          (i_clk),
                .i_ctl          (ctl),
                .i_occ          (occ[g]),
                .i_new_key      (i_entry_key),
                .i_new_payload  (i_entry_payload),
                .i_prev_gt      (gt[g-1]),
                .i_prev_key     (cell_key[g-1]),
                .i_prev_payload (cell_payload[g-1]),
                .i_next_key     (cell_key[g]),
                .i_next_payload (cell_payload[g]),
                .o_gt           (gt[g]),
                .o_key          (cell_key[g]),
                .o_payload      (cell_payload[g])
            );
        end else begin : g_mid
            sspq_cell u_cell (
                .i_clk          (i_clk),
                .i_ctl          (ctl),
                .i_occ          (occ[g]),
                .i_new_key      (i_entry_key),
                .i_new_payload  (i_entry_payload),
                .i_prev_gt      (gt[g-1]),
                .i_prev_key     (cell_key[g-1]),
                .i_prev_payload (cell_payload[g-1]),
                .i_next_key     (cell_key[g+1]),
                .i_next_payload (cell_payload[g+1]),
                .o_gt           (gt[g]),
                .o_key          (cell_key[g]),
                .o_payload      (cell_payload[g])
            );
        end
    end

    always_comb begin
        n_count   = r_count;
        n_status  = sspq_pkg::ST_DONE;
        n_key     = '0;
        n_payload = '0;
        if (ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (ctl.rem) begin
            n_count   = r_count - 1'b1;
            n_key     = cell_key[0];
            n_payload = cell_payload[0];
        end else if (i_opcode == sspq_pkg::OP_INSERT) begin
            n_status = sspq_pkg::ST_FULL;
        end else begin
            n_status = sspq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_key       <= n_key;
            r_payload   <= n_payload;
            r_out_count <= n_count;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_key     = r_key;
    assign o_out_payload = r_payload;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = (r_out_count == '0);
    assign o_is_full     = (r_out_count == sspq_pkg::CNT_BITS'(D));

endmodule

// ===== hdl/sspq_chk.sv =====
// Port-level checker for the stable sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module sspq_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [1:0]                          o_status,
    input logic [sspq_pkg::KEY_BITS-1:0]       o_out_key,
    input logic [sspq_pkg::PAYLOAD_BITS-1:0]   o_out_payload,
    input logic [sspq_pkg::CNT_BITS-1:0]       o_entry_count,
    input logic                                o_is_empty,
    input logic                                o_is_full
);

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_full == (o_entry_count == sspq_pkg::CNT_BITS'(sspq_pkg::DEPTH))))
        else $error("full flag disagrees with count");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != sspq_pkg::ST_DONE)) |->
            (o_out_key == '0 && o_out_payload == '0))
        else $error("rejected item carries an entry");

    a_reject_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == sspq_pkg::ST_FULL || o_status == sspq_pkg::ST_EMPTY)) |->
            ((o_status == sspq_pkg::ST_FULL && o_is_full) ||
             (o_status == sspq_pkg::ST_EMPTY && o_is_empty)))
        else $error("rejection status does not match occupancy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_out_key)
            && $stable(o_out_payload) && $stable(o_entry_count)))
        else $error("stalled transfer changed");

endmodule

bind stable_sorted_priority_queue sspq_chk u_sspq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_out_key     (o_out_key),
    .o_out_payload (o_out_payload),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty),
    .o_is_full     (o_is_full)
);
